@@ sv/clkd_pkg.sv @@
// ----------------------------------------------------------------------------
// clkd_pkg
// Shared constants, keyword table and result types for the keyword decoder.
// ----------------------------------------------------------------------------
package clkd_pkg;

	localparam int LineBytes = 100;
	localparam int CountW    = $clog2(LineBytes);
	localparam int KwCount   = 11;
	localparam int KwMax     = 14;

	localparam logic [7:0] CHAR_CR   = 8'd13;
	localparam logic [7:0] CHAR_LF   = 8'd10;
	localparam logic [7:0] CHAR_NUL  = 8'd0;

	// keyword indexes
	localparam int KW_RING     = 0;
	localparam int KW_NOCARR   = 1;
	localparam int KW_GPSMODE  = 2;
	localparam int KW_GPSOK    = 3;
	localparam int KW_FREE     = 4;
	localparam int KW_PATH     = 5;
	localparam int KW_JOYMODE  = 6;
	localparam int KW_UP       = 7;
	localparam int KW_DOWN     = 8;
	localparam int KW_LEFT     = 9;
	localparam int KW_RIGHT    = 10;

	localparam logic [2:0] MODE_GPS  = 3'd1;
	localparam logic [2:0] MODE_FREE = 3'd2;
	localparam logic [2:0] MODE_JOY  = 3'd3;
	localparam logic [2:0] MODE_PATH = 3'd4;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_TEXT   = 2'd1;
	localparam logic [1:0] KIND_JOY    = 2'd2;

	localparam logic [3:0] PINS_UP    = 4'd12;
	localparam logic [3:0] PINS_DOWN  = 4'd3;
	localparam logic [3:0] PINS_LEFT  = 4'd9;
	localparam logic [3:0] PINS_RIGHT = 4'd6;

	typedef logic [KwMax-1:0] kw_prog_t;

	// Byte of keyword k at position j, zero past its end.
	function automatic logic [7:0] kw_char(input int k, input int j);
		string s;
		s = "";
		case (k)
			0: s = "RING";
			1: s = "NO CARRIER";
			2: s = "GPS Mode";
			3: s = "GPS OK";
			4: s = "Free Mode";
			5: s = "Path Mode";
			6: s = "Joystick Mode";
			7: s = "Joystick Up";
			8: s = "Joystick Down";
			9: s = "Joystick Left";
			default: s = "Joystick Right";
		endcase
		if (j < s.len()) return s[j];
		return 8'd0;
	endfunction

	function automatic int kw_len(input int k);
		case (k)
			0: return 4;
			1: return 10;
			2: return 8;
			3: return 6;
			4: return 9;
			5: return 9;
			6: return 13;
			7: return 11;
			8: return 13;
			9: return 13;
			default: return 14;
		endcase
	endfunction

	// Per-byte control handed along the cell row.
	typedef struct packed {
		logic       step;   // a kept, searchable byte
		logic       clear;  // end of line: restart
		logic [7:0] ch;
	} cell_ctl_t;

endpackage

@@ sv/clkd_cell.sv @@
// ----------------------------------------------------------------------------
// clkd_cell
// One shift-and matcher cell: tracks progress of one keyword, sets its seen bit.
// ----------------------------------------------------------------------------
module clkd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  clkd_pkg::cell_ctl_t ctl,
	input  logic [7:0]        kw_sel,
	output logic              seen
);
	import clkd_pkg::*;

	kw_prog_t prog_q;
	kw_prog_t mask;
	kw_prog_t prog_nxt;
	logic     seen_q;
	int       klen;

	// build the byte mask for this keyword
	always_comb begin
		klen = kw_len(int'(kw_sel));
		for (int j = 0; j < KwMax; j++) begin
			mask[j] = (j < klen) && (kw_char(int'(kw_sel), j) == ctl.ch);
		end
		prog_nxt = {prog_q[KwMax-2:0], 1'b1} & mask;
	end

	// advance match progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= '0;
			seen_q <= 1'b0;
		end else if (ctl.clear) begin
			prog_q <= '0;
			seen_q <= 1'b0;
		end else if (ctl.step) begin
			prog_q <= prog_nxt;
			if (prog_nxt[klen-1]) seen_q <= 1'b1;
		end
	end

	assign seen = seen_q;
endmodule

@@ sv/command_line_keyword_decoder_top.sv @@
// ----------------------------------------------------------------------------
// command_line_keyword_decoder_top
// Line assembler with a row of keyword matcher cells and end-of-line decode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rx_valid/rx_ready carries one received byte per word.
//   Line feed is dropped; carriage return closes the line and yields one
//   output word on out_valid/out_ready; other bytes yield nothing.
//   Every searchable byte steps all eleven matcher cells as it is taken,
//   so one byte is accepted per cycle unless a carriage return is held;
//   a line's result is registered as its carriage return is accepted.
//   The output register frees as it is read, so a new word may enter in
//   the same cycle the old one leaves; while a result waits unread, bytes
//   keep flowing until the next carriage return, which then waits.
//   Reset clears the line, the mode, pins, GPS flag and targets at once.
module command_line_keyword_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        connected,
	output logic        disconnected,
	output logic [2:0]  move_mode,
	output logic [1:0]  line_kind,
	output logic [3:0]  motor_pins,
	output logic        gps_ready,
	output logic [15:0] target_lat,
	output logic [15:0] target_lon
);
	import clkd_pkg::*;

	logic [CountW-1:0] count_q;
	logic              ended_q;
	logic [7:0]        dig_q [6];
	logic [KwCount-1:0] seen;
	logic [2:0]        mode_q;
	logic [3:0]        pin_q;
	logic              gps_q;
	logic [15:0]       lat_q, lon_q;
	logic              full_q;
	logic              is_cr, is_lf, take, keep, eol;
	cell_ctl_t         ctl;
	logic [2:0]        mode_n;
	logic [3:0]        pin_n;
	logic [1:0]        kind_n;
	logic [15:0]       lat_n, lon_n;

	assign is_cr = rx_byte == CHAR_CR;
	assign is_lf = rx_byte == CHAR_LF;
	assign rx_ready = !(is_cr && full_q && !out_ready);
	assign take = rx_valid && rx_ready;
	assign eol = take && is_cr;
	assign keep = take && !is_cr && !is_lf && (32'(count_q) < LineBytes - 1);

	assign ctl.ch = rx_byte;
	assign ctl.clear = eol;
	assign ctl.step = keep && !ended_q && (rx_byte != CHAR_NUL);

	// matcher cell row
	for (genvar k = 0; k < KwCount; k++) begin : g_cell
		clkd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.kw_sel(8'(k)), .seen(seen[k])
		);
	end

	// track line position, end of text and digit captures
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ended_q <= 1'b0;
			for (int i = 0; i < 6; i++) dig_q[i] <= '0;
		end else if (eol) begin
			count_q <= '0;
			ended_q <= 1'b0;
			for (int i = 0; i < 6; i++) dig_q[i] <= '0;
		end else if (keep) begin
			count_q <= count_q + 1'b1;
			if (rx_byte == CHAR_NUL) ended_q <= 1'b1;
			if (32'(count_q) == 9)  dig_q[0] <= rx_byte;
			if (32'(count_q) == 10) dig_q[1] <= rx_byte;
			if (32'(count_q) == 11) dig_q[2] <= rx_byte;
			if (32'(count_q) == 15) dig_q[3] <= rx_byte;
			if (32'(count_q) == 16) dig_q[4] <= rx_byte;
			if (32'(count_q) == 17) dig_q[5] <= rx_byte;
		end
	end

	// decode the closed line
	always_comb begin
		mode_n = mode_q;
		if (seen[KW_GPSMODE]) mode_n = MODE_GPS;
		if (seen[KW_FREE])    mode_n = MODE_FREE;
		if (seen[KW_PATH])    mode_n = MODE_PATH;
		if (seen[KW_JOYMODE]) mode_n = MODE_JOY;
		pin_n = pin_q;
		if (seen[KW_UP])    pin_n = PINS_UP;
		if (seen[KW_DOWN])  pin_n = PINS_DOWN;
		if (seen[KW_LEFT])  pin_n = PINS_LEFT;
		if (seen[KW_RIGHT]) pin_n = PINS_RIGHT;
		if (|seen[KW_RIGHT:KW_UP])      kind_n = KIND_JOY;
		else if (|seen[KW_JOYMODE:0])   kind_n = KIND_STATUS;
		else                            kind_n = KIND_TEXT;
		lat_n = 16'(16'(dig_q[0]) * 16'd100 + 16'(dig_q[1]) * 16'd10
			+ 16'(dig_q[2]) - 16'd5328);
		lon_n = 16'(16'(dig_q[3]) * 16'd100 + 16'(dig_q[4]) * 16'd10
			+ 16'(dig_q[5]) - 16'd5328);
	end

	// hold persistent state and the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			pin_q <= '0;
			gps_q <= 1'b0;
			lat_q <= '0;
			lon_q <= '0;
			full_q <= 1'b0;
			connected <= 1'b0;
			disconnected <= 1'b0;
			line_kind <= KIND_STATUS;
		end else begin
			if (full_q && out_ready) full_q <= 1'b0;
			if (eol) begin
				full_q <= 1'b1;
				mode_q <= mode_n;
				pin_q <= pin_n;
				if (seen[KW_GPSOK]) begin
					gps_q <= 1'b1;
					lat_q <= lat_n;
					lon_q <= lon_n;
				end
				connected <= seen[KW_RING];
				disconnected <= seen[KW_NOCARR];
				line_kind <= kind_n;
			end
		end
	end

	assign out_valid = full_q;
	assign move_mode = mode_q;
	assign motor_pins = pin_q;
	assign gps_ready = gps_q;
	assign target_lat = lat_q;
	assign target_lon = lon_q;
endmodule
